// File: rtl/core/dhpm_pkg.sv
// Package for the double-hashed paged memory: request codes and constants.
// No dependencies.
`default_nettype none
package dhpm_pkg;
    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_SEARCH = 3'd1;
    localparam logic [2:0] REQ_DELETE = 3'd2;
    localparam logic [2:0] REQ_WRITE  = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;
    localparam logic       CFG_SLOTS  = 1'b0;
    localparam logic       CFG_PAGE   = 1'b1;
endpackage
`default_nettype wire

// File: rtl/core/double_hash_paged_memory.sv
// Double-hashed process page table over a paged word memory.
// Each beat runs two bit-serial divide passes by m (pid mod m, then the
// quotient mod m), a probe walk over all m slots and the finish states
// ST_MEM, ST_RDW (read only) and ST_OUT; the next beat is accepted only once
// the result has moved into the output register.
// Reset (synchronous, active low) clears the slot-used flags and the registers
// to 64 slots and 64 page words; pid and page memories are not cleared.
`default_nettype none
module double_hash_paged_memory
    import dhpm_pkg::*;
#(
    parameter int NUM_SLOTS      = 64,
    parameter int MAX_PAGE_WORDS = 64,
    parameter int DATA_WIDTH     = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire  [6:0]  i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: req_type[2:0], process_id[34:3], word_addr[40:35], write_data[72:41]
    input  wire  [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // tdata: status[0], slot_index[6:1], read_data[38:7], echo_addr[44:39]
    output logic [47:0] m_axis_tdata
);
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int PW = $clog2(MAX_PAGE_WORDS + 1);
    localparam int MW = $clog2(NUM_SLOTS * MAX_PAGE_WORDS) > 0 ?
                        $clog2(NUM_SLOTS * MAX_PAGE_WORDS) : 1;
    localparam int DEPTH = NUM_SLOTS * MAX_PAGE_WORDS;
    localparam int DRW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_PROBE = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;
    localparam logic [2:0] ST_MEM  = 3'd4;
    localparam logic [2:0] ST_RDW  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [6:0] r_slots, r_page;
    logic [2:0] r_state;
    logic [2:0] r_type;
    logic [31:0] r_pid, r_quo;
    logic [5:0] r_addr;
    logic [DATA_WIDTH-1:0] r_wdata;
    logic [CW-1:0] r_m;
    logic [PW-1:0] r_pw;
    logic [CW-1:0] r_rem;
    logic [5:0] r_bit;
    logic [SW-1:0] r_h, r_step, r_pos;
    logic [CW-1:0] r_i;
    logic r_vld;
    logic [SW-1:0] r_chk;
    logic r_found, r_free_ok;
    logic [SW-1:0] r_found_s, r_free_s;
    logic [NUM_SLOTS-1:0] r_used;
    logic [31:0] pid_mem [NUM_SLOTS];
    logic [DATA_WIDTH-1:0] page_mem [DEPTH];
    logic [31:0] r_pid_rd;
    logic [DATA_WIDTH-1:0] r_page_rd;
    logic [MW-1:0] r_waddr;
    logic r_ok;
    logic [47:0] r_res;
    logic [47:0] r_out;
    logic r_ovld;

    // Effective register values with saturation.
    logic [CW-1:0] eff_m;
    logic [PW-1:0] eff_pw;
    always_comb begin
        if (r_slots == 7'd0) eff_m = CW'(1);
        else if (32'(r_slots) > NUM_SLOTS) eff_m = CW'(NUM_SLOTS);
        else eff_m = CW'(r_slots);
        if (32'(r_page) > MAX_PAGE_WORDS) eff_pw = PW'(MAX_PAGE_WORDS);
        else eff_pw = PW'(r_page);
    end

    // Restoring divider step: one quotient bit a cycle.
    logic [CW:0] rem_sh;
    logic rem_ge;
    assign rem_sh = {r_rem, r_pid[r_bit[4:0]]};
    assign rem_ge = rem_sh >= {1'b0, r_m};

    // Modular add for the next probe position.
    logic [CW:0] pos_sum;
    logic [SW-1:0] pos_next;
    assign pos_sum = (CW+1)'(r_pos) + (CW+1)'(r_step);
    assign pos_next = (pos_sum >= (CW+1)'(r_m)) ? SW'(pos_sum - (CW+1)'(r_m)) : SW'(pos_sum);

    logic hit;
    assign hit = r_vld && r_used[r_chk] && (r_pid_rd == r_pid);

    logic [2*SW+PW:0] word_idx;
    assign word_idx = (2*SW+PW+1)'(r_found_s) * (2*SW+PW+1)'(r_pw) + (2*SW+PW+1)'(r_addr);

    // Outcome of the request once the probe walk is over.
    logic page_ok;
    logic mem_ok;
    logic [5:0] mem_slot;
    logic [5:0] mem_echo;
    always_comb begin
        page_ok = r_found && (32'(r_addr) < 32'(r_pw)) &&
                  (word_idx < (2*SW+PW+1)'(DEPTH));
        mem_ok   = 1'b0;
        mem_slot = '0;
        mem_echo = '0;
        case (r_type)
            REQ_INSERT: begin
                if (!r_found && r_free_ok) begin
                    mem_ok   = 1'b1;
                    mem_slot = 6'(r_free_s);
                end
            end
            REQ_SEARCH, REQ_DELETE: begin
                if (r_found) begin
                    mem_ok   = 1'b1;
                    mem_slot = 6'(r_found_s);
                end
            end
            REQ_WRITE: begin
                if (page_ok) begin
                    mem_ok   = 1'b1;
                    mem_slot = 6'(r_found_s);
                end
            end
            REQ_READ: begin
                if (page_ok) begin
                    mem_ok   = 1'b1;
                    mem_slot = 6'(r_found_s);
                    mem_echo = r_addr;
                end
            end
            default: ;
        endcase
    end

    // The finished result moves into the output register once it is free; until
    // then the block stays in ST_OUT and takes no new request beat.
    logic out_load;
    assign out_load = (r_state == ST_OUT) && (!r_ovld || m_axis_tready);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= 7'd64;
            r_page  <= 7'd64;
            r_state <= ST_IDLE;
            r_used  <= '0;
            r_ovld  <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_SLOTS) r_slots <= i_cfg_data;
                else r_page <= i_cfg_data;
            end
            if (out_load) r_ovld <= 1'b1;
            else if (m_axis_tready) r_ovld <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_type  <= s_axis_tdata[2:0];
                        r_pid   <= s_axis_tdata[34:3];
                        r_addr  <= s_axis_tdata[40:35];
                        r_wdata <= DATA_WIDTH'(s_axis_tdata[72:41]);
                        r_m     <= eff_m;
                        r_pw    <= eff_pw;
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_bit   <= 6'd31;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem <= rem_ge ? CW'(rem_sh - {1'b0, r_m}) : CW'(rem_sh);
                    r_quo <= {r_quo[30:0], rem_ge};
                    if (r_bit == 6'd0) begin
                        r_state <= ST_DONE;  // reduce quotient next
                        r_h     <= rem_ge ? SW'(rem_sh - {1'b0, r_m}) : SW'(rem_sh);
                        r_bit   <= 6'd32;
                    end else begin
                        r_bit <= r_bit - 6'd1;
                    end
                end
                ST_DONE: begin
                    // Second pass over the quotient gives step = quo mod m, forced odd.
                    if (r_bit == 6'd32) begin
                        r_pid <= r_quo;
                        r_quo <= r_pid;
                        r_rem <= '0;
                        r_bit <= 6'd31;
                    end else begin
                        r_rem <= rem_ge ? CW'(rem_sh - {1'b0, r_m}) : CW'(rem_sh);
                        if (r_bit == 6'd0) begin
                            r_step <= (rem_ge ? SW'(rem_sh - {1'b0, r_m}) : SW'(rem_sh))
                                      | SW'(1);
                            r_pid  <= r_quo;
                            r_pos  <= r_h;
                            r_i    <= '0;
                            r_found <= 1'b0;
                            r_free_ok <= 1'b0;
                            r_vld  <= 1'b0;
                            r_state <= ST_PROBE;
                        end else begin
                            r_bit <= r_bit - 6'd1;
                        end
                    end
                end
                ST_PROBE: begin
                    // Issue probe i, check result of probe i-1 from the pid memory.
                    if (hit && !r_found) begin
                        r_found <= 1'b1;
                        r_found_s <= r_chk;
                    end
                    if (r_vld && !r_used[r_chk] && !r_free_ok) begin
                        r_free_ok <= 1'b1;
                        r_free_s <= r_chk;
                    end
                    if (r_i == r_m) begin
                        r_vld <= 1'b0;
                        r_state <= ST_MEM;
                    end else begin
                        r_vld <= 1'b1;
                        r_chk <= r_pos;
                        r_pos <= pos_next;
                        r_i <= r_i + CW'(1);
                    end
                end
                ST_MEM: begin
                    r_ok    <= mem_ok && (r_type == REQ_WRITE || r_type == REQ_READ);
                    r_res   <= {3'b0, mem_echo, 32'd0, mem_slot, !mem_ok};
                    r_waddr <= MW'(word_idx);
                    r_state <= (mem_ok && r_type == REQ_READ) ? ST_RDW : ST_OUT;
                    if (mem_ok && r_type == REQ_INSERT) r_used[r_free_s] <= 1'b1;
                    if (mem_ok && r_type == REQ_DELETE) r_used[r_found_s] <= 1'b0;
                end
                ST_RDW: begin
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_out <= {r_res[47:39],
                                  (r_ok && r_type == REQ_READ) ?
                                      32'(r_page_rd[DRW-1:0]) : 32'd0,
                                  r_res[6:0]};
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Pid memory: written on insert, read each probe cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MEM && r_type == REQ_INSERT && !r_found && r_free_ok)
            pid_mem[r_free_s] <= r_pid;
        r_pid_rd <= pid_mem[r_pos];
    end

    // Page memory: one write or one registered read per request.
    always_ff @(posedge i_clk) begin
        if (out_load && r_ok && r_type == REQ_WRITE)
            page_mem[r_waddr] <= r_wdata;
        r_page_rd <= page_mem[r_waddr];
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ST_OUT)) else $error("stray result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE) |-> (r_i <= r_m)) else $error("probe overrun");
endmodule
`default_nettype wire

// File: tb/sv/double_hash_paged_memory_test.sv
// Self-checking testbench for the double-hashed process page table.
// Depends on dhpm_pkg and double_hash_paged_memory; needs nothing else.
`default_nettype none
module double_hash_paged_memory_test;
    import dhpm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Request codes the block does not know; they must fail without side effects.
    localparam logic [2:0] REQ_BAD_FIRST = 3'd5;
    localparam logic [2:0] REQ_BAD_LAST  = 3'd7;
    localparam int         TABLE_SLOTS   = 64;
    localparam int         PAGE_MAX      = 64;
    localparam int         CYCLE_LIMIT   = 2000000;
    localparam int         SETTLE_CYCLES = 20;

    // Idling modes of the two stream sides.
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // Request beat, last field in the lowest bits.
    typedef struct packed {
        logic [31:0] data;
        logic [5:0]  addr;
        logic [31:0] pid;
        logic [2:0]  kind;
    } request_t;

    // Response beat, last field in the lowest bits.
    typedef struct packed {
        logic [5:0]  echo;
        logic [31:0] rdata;
        logic [5:0]  slot;
        logic        status;
    } response_t;

    // Mirror of the page table: it predicts one response per accepted request
    // and compares responses in order against those predictions.
    class page_table_scoreboard;
        bit          used[TABLE_SLOTS];
        bit [31:0]   owner[TABLE_SLOTS];
        bit [31:0]   words[TABLE_SLOTS*PAGE_MAX];
        bit          written[TABLE_SLOTS*PAGE_MAX];
        int unsigned slots_reg = 64;
        int unsigned page_reg  = 64;
        response_t   awaited[$];
        int unsigned errors;

        function int unsigned live_slots();
            if (slots_reg == 0) return 1;
            if (slots_reg > TABLE_SLOTS) return TABLE_SLOTS;
            return slots_reg;
        endfunction

        function int unsigned live_page();
            if (page_reg > PAGE_MAX) return PAGE_MAX;
            return page_reg;
        endfunction

        // Probe i of the double-hash sequence; the stride is forced odd.
        function int unsigned probe(bit [31:0] pid, int unsigned i, int unsigned m);
            longint unsigned stride;
            stride = (pid / m) % m;
            if (stride[0] == 1'b0) stride = stride + 1;
            return 32'(((pid % m) + i * stride) % m);
        endfunction

        // Slot holding pid, or -1 once all m probes are walked.
        function int find_owner(bit [31:0] pid);
            int unsigned m;
            int unsigned s;
            m = live_slots();
            for (int unsigned i = 0; i < m; i++) begin
                s = probe(pid, i, m);
                if (used[s] && owner[s] == pid) return s;
            end
            return -1;
        endfunction

        // True when a read would land on a page word nobody has written yet.
        function bit blank_read(request_t r);
            int s;
            s = find_owner(r.pid);
            return r.kind == REQ_READ && s >= 0 && r.addr < live_page() &&
                   !written[s * live_page() + r.addr];
        endfunction

        function void note_request(request_t r);
            response_t   rsp;
            int          s;
            int unsigned m;
            int unsigned p;
            int unsigned w;
            rsp = '0;
            rsp.status = 1'b1;
            m = live_slots();
            s = find_owner(r.pid);
            case (r.kind)
                REQ_INSERT: begin
                    if (s < 0) begin
                        for (int unsigned i = 0; i < m; i++) begin
                            p = probe(r.pid, i, m);
                            if (!used[p]) begin
                                used[p]    = 1'b1;
                                owner[p]   = r.pid;
                                rsp.status = 1'b0;
                                rsp.slot   = 6'(p);
                                break;
                            end
                        end
                    end
                end
                REQ_SEARCH, REQ_DELETE: begin
                    if (s >= 0) begin
                        // A delete frees the slot but leaves the page contents alone.
                        if (r.kind == REQ_DELETE) used[s] = 1'b0;
                        rsp.status = 1'b0;
                        rsp.slot   = 6'(s);
                    end
                end
                REQ_WRITE, REQ_READ: begin
                    if (s >= 0 && r.addr < live_page()) begin
                        w = s * live_page() + r.addr;
                        if (r.kind == REQ_WRITE) begin
                            words[w]   = r.data;
                            written[w] = 1'b1;
                        end else begin
                            rsp.rdata = words[w];
                            rsp.echo  = r.addr;
                        end
                        rsp.status = 1'b0;
                        rsp.slot   = 6'(s);
                    end
                end
                default: ;
            endcase
            awaited.push_back(rsp);
        endfunction

        function void check_result(response_t got);
            response_t want;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected response beat %h", got);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.slot !== want.slot ||
                got.rdata !== want.rdata || got.echo !== want.echo) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: status %0d/%0d slot %0d/%0d data %h/%h echo %0d/%0d",
                             want.status, got.status, want.slot, got.slot,
                             want.rdata, got.rdata, want.echo, got.echo);
            end
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_index   = CFG_SLOTS;
    logic [6:0]  i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    page_table_scoreboard table_model = new();
    idle_mode_t           idle_mode   = IDLE_NONE;
    int unsigned          cycle_count = 0;
    bit [31:0]            pid_pool[16];

    double_hash_paged_memory i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("double_hash_paged_memory_test: FAIL");
            $finish;
        end
    end

    // Response side: check each accepted beat, then choose whether to stall
    // in the following cycle according to the current idling mode.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            table_model.check_result(response_t'(m_axis_tdata[44:0]));
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else if (idle_mode == IDLE_RECEIVER)
            m_axis_tready <= ($urandom_range(99) >= 88);
        else if (idle_mode == IDLE_BOTH)
            m_axis_tready <= ($urandom_range(99) >= 9);
        else
            m_axis_tready <= 1'b1;
    end

    task automatic wait_drained();
        while (table_model.awaited.size() != 0) @(posedge i_clk);
    endtask

    // Registers are only changed with the block idle: every response is in and
    // a settling wait has passed.
    task automatic set_registers(input int unsigned slots, input int unsigned page);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SLOTS;
        i_cfg_data  <= 7'(slots);
        @(posedge i_clk);
        i_cfg_index <= CFG_PAGE;
        i_cfg_data  <= 7'(page);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        table_model.slots_reg = slots;
        table_model.page_reg  = page;
    endtask

    // Offers one request beat and returns in the step of its acceptance. The
    // valid stays high so that back-to-back beats need no extra assignment.
    task automatic send_request(input request_t r);
        int unsigned gap;
        gap = 0;
        if (idle_mode == IDLE_SENDER)
            while ($urandom_range(99) < 88) gap++;
        else if (idle_mode == IDLE_BOTH)
            while ($urandom_range(99) < 9) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        // A read of a page word that was never written is steered to a write.
        if (table_model.blank_read(r)) r.kind = REQ_WRITE;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, r};
        do @(posedge i_clk); while (!s_axis_tready);
        table_model.note_request(r);
    endtask

    task automatic request(input logic [2:0] kind, input bit [31:0] pid,
                           input bit [5:0] addr, input bit [31:0] data);
        request_t r;
        r.kind = kind;
        r.pid  = pid;
        r.addr = addr;
        r.data = data;
        send_request(r);
    endtask

    // Fresh ids: small values collide on the hash, wide ones exercise every bit.
    task automatic fill_pid_pool();
        for (int i = 0; i < 16; i++)
            case ($urandom_range(3))
                0: pid_pool[i] = $urandom_range(200);
                1: pid_pool[i] = 32'hFFFF_FFFF - $urandom_range(200);
                default: pid_pool[i] = $urandom;
            endcase
    endtask

    // Random traffic over a small id pool so that hits, misses, full tables
    // and reused slots all come up; a few beats carry unknown codes.
    task automatic random_phase(input int unsigned count, input bit drain_often);
        request_t    r;
        int unsigned pick;
        fill_pid_pool();
        for (int unsigned n = 0; n < count; n++) begin
            pick   = $urandom_range(99);
            r.pid  = pid_pool[$urandom_range(15)];
            r.addr = 6'($urandom_range(63));
            r.data = $urandom;
            if (pick < 25)       r.kind = REQ_INSERT;
            else if (pick < 38)  r.kind = REQ_SEARCH;
            else if (pick < 50)  r.kind = REQ_DELETE;
            else if (pick < 75)  r.kind = REQ_WRITE;
            else if (pick < 97)  r.kind = REQ_READ;
            else                 r.kind = 3'($urandom_range(REQ_BAD_FIRST, REQ_BAD_LAST));
            if (pick >= 94 && pick < 97) r.pid = $urandom;
            send_request(r);
            if (drain_often && n % 40 == 39) begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset setting of 64 slots and 64 words per page.
        set_registers(64, 64);
        request(REQ_INSERT, 32'h0, 6'd0, 32'h0);
        request(REQ_INSERT, 32'h0, 6'd0, 32'h0);            // duplicate id
        request(REQ_INSERT, 32'hFFFF_FFFF, 6'd0, 32'h0);
        request(REQ_SEARCH, 32'hFFFF_FFFF, 6'd0, 32'h0);
        request(REQ_SEARCH, 32'h0001_2345, 6'd0, 32'h0);    // absent id
        request(REQ_WRITE, 32'h0, 6'd63, 32'h8000_0000);
        request(REQ_WRITE, 32'hFFFF_FFFF, 6'd0, 32'h7FFF_FFFF);
        request(REQ_READ, 32'h0, 6'd63, 32'h0);
        request(REQ_READ, 32'hFFFF_FFFF, 6'd0, 32'h0);
        request(REQ_WRITE, 32'h0001_2345, 6'd1, 32'hFFFF_FFFF);
        request(REQ_READ, 32'h0001_2345, 6'd1, 32'h0);
        request(REQ_DELETE, 32'h0, 6'd0, 32'h0);
        request(REQ_READ, 32'h0, 6'd63, 32'h0);             // freed slot
        request(REQ_DELETE, 32'h0, 6'd0, 32'h0);
        // Reinserting lands in the same slot, and the old page word survives.
        request(REQ_INSERT, 32'h0, 6'd0, 32'h0);
        request(REQ_READ, 32'h0, 6'd63, 32'h0);
        for (int k = REQ_BAD_FIRST; k <= REQ_BAD_LAST; k++)
            request(k[2:0], 32'h0, 6'd63, 32'hFFFF_FFFF);
        s_axis_tvalid <= 1'b0;

        // One slot with three-word pages: a full table and an out-of-page address.
        set_registers(1, 3);
        request(REQ_INSERT, 32'd7, 6'd0, 32'h0);
        request(REQ_INSERT, 32'd9, 6'd0, 32'h0);
        request(REQ_WRITE, 32'd7, 6'd2, 32'h5A5A_A5A5);
        request(REQ_WRITE, 32'd7, 6'd3, 32'h1234_5678);
        request(REQ_READ, 32'd7, 6'd2, 32'h0);
        s_axis_tvalid <= 1'b0;

        // A zero slot count acts as one, oversize pages saturate, and pages move.
        set_registers(0, 127);
        request(REQ_READ, 32'd7, 6'd2, 32'h0);
        request(REQ_WRITE, 32'd7, 6'd63, 32'hCAFE_0001);
        s_axis_tvalid <= 1'b0;
        set_registers(2, 0);                                // zero-word pages
        request(REQ_WRITE, 32'd7, 6'd0, 32'h1);
        request(REQ_READ, 32'd7, 6'd0, 32'h0);
        s_axis_tvalid <= 1'b0;

        // Random part, several register settings and idling modes.
        idle_mode = IDLE_NONE;
        set_registers(64, 64);
        random_phase(300, 1'b0);
        idle_mode = IDLE_SENDER;
        set_registers(8, 8);
        random_phase(250, 1'b0);
        idle_mode = IDLE_RECEIVER;
        set_registers(1, 3);
        random_phase(150, 1'b0);
        idle_mode = IDLE_BOTH;
        set_registers(127, 127);
        random_phase(300, 1'b0);
        idle_mode = IDLE_RECEIVER;
        set_registers(13, 0);
        random_phase(150, 1'b0);
        idle_mode = IDLE_NONE;
        set_registers(5, 64);
        random_phase(200, 1'b1);                            // drains every 40 beats
        idle_mode = IDLE_BOTH;
        set_registers(64, 1);
        random_phase(300, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (table_model.errors == 0)
            $display("double_hash_paged_memory_test: PASS");
        else
            $display("double_hash_paged_memory_test: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
